>>> src/obd_pkg.sv
`default_nettype none
package obd_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int PAYLOAD_W  = 32;

   // register index = paddr[4:2]
   typedef enum logic [2:0] {
      CSR_SAMPLES_PER_BIT  = 3'd0,
      CSR_ONE_THRESHOLD    = 3'd1,
      CSR_PREAMBLE_PATTERN = 3'd2,
      CSR_PAYLOAD_BITS     = 3'd3,
      CSR_TRAILER_BITS     = 3'd4,
      CSR_TRAILER_PATTERN  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_TRAILER = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE         = 3'd0,
      EV_PREAMBLE     = 3'd1,
      EV_PAYLOAD      = 3'd2,
      EV_TRAILER_GOOD = 3'd3,
      EV_TRAILER_BAD  = 3'd4
   } event_type;

   localparam logic [7:0]  SAMPLES_PER_BIT_RESET  = 8'd10;
   localparam logic [7:0]  ONE_THRESHOLD_RESET    = 8'd7;
   localparam logic [31:0] PREAMBLE_PATTERN_RESET = 32'h0000_FFFF;
   localparam logic [5:0]  PAYLOAD_BITS_RESET     = 6'd8;
   localparam logic [5:0]  TRAILER_BITS_RESET     = 6'd16;
   localparam logic [31:0] TRAILER_PATTERN_RESET  = 32'h0000_0001;

   localparam logic [7:0]  HIGH_COUNT_MAX = 8'hFF;
   localparam logic [5:0]  BIT_COUNT_MAX  = 6'h3F;

endpackage
`default_nettype wire

>>> src/obd_if.sv
`default_nettype none
interface obd_req_if;
   logic valid;
   logic ready;
   logic level;

   modport source (output valid, output level, input ready);
   modport sink (input valid, input level, output ready);
endinterface

interface obd_rsp_if;
   logic                valid;
   logic                ready;
   logic                bit_value;
   obd_pkg::event_type  event_res;
   logic [31:0]         payload;
   logic                marker;

   modport source (output valid, output bit_value, output event_res, output payload,
                   output marker, input ready);
   modport sink (input valid, input bit_value, input event_res, input payload,
                 input marker, output ready);
endinterface
`default_nettype wire

>>> src/oversampled_bit_deframer_top.sv
// Oversampled bit slicer and preamble / payload / trailer deframer.
//
// req_if carries one comparator sample (level) per word. Every word is
// counted; only the word that closes a bit period (samples_per_bit samples,
// 256 when the register is zero) yields a word on rsp_if: the decided bit,
// the framing event, the last captured payload and the marker pin.
//
// Latency: the result word is valid on the cycle after the closing sample is
// accepted. Throughput: one sample per clock while no closing sample stalls,
// set by the single registered pass of counters and compares between the state
// registers and the result register.
//
// Stall: a sample that does not close a period is always taken. A closing
// sample is taken only when the result register is empty or drained in the
// same cycle, so a stalled receiver holds back only the closing sample.
//
// Reset (synchronous, active high): counters, history and payload clear, the
// phase returns to hunt, the marker drops, CSRs take defaults. The CSRs sit
// at 4*index on APB and must be written only while idle (left unchecked).
`default_nettype none
module oversampled_bit_deframer_top #(
   parameter int HISTORY_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   obd_req_if.sink                             req_if,
   obd_rsp_if.source                           rsp_if,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [obd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [obd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [obd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);
   import obd_pkg::*;

   // compare width: history and 32-bit patterns both zero-extended to this
   localparam int CW = (HISTORY_WIDTH > PAYLOAD_W) ? HISTORY_WIDTH : PAYLOAD_W;

   // ---------------- CSRs ----------------
   logic [7:0]  spb_ff, thr_ff;
   logic [31:0] pre_ff, tpat_ff;
   logic [5:0]  pay_ff, trl_ff;
   logic        csr_wr;
   csr_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         spb_ff  <= SAMPLES_PER_BIT_RESET;
         thr_ff  <= ONE_THRESHOLD_RESET;
         pre_ff  <= PREAMBLE_PATTERN_RESET;
         pay_ff  <= PAYLOAD_BITS_RESET;
         trl_ff  <= TRAILER_BITS_RESET;
         tpat_ff <= TRAILER_PATTERN_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_SAMPLES_PER_BIT:  spb_ff  <= csr_pwdata[7:0];
            CSR_ONE_THRESHOLD:    thr_ff  <= csr_pwdata[7:0];
            CSR_PREAMBLE_PATTERN: pre_ff  <= csr_pwdata;
            CSR_PAYLOAD_BITS:     pay_ff  <= csr_pwdata[5:0];
            CSR_TRAILER_BITS:     trl_ff  <= csr_pwdata[5:0];
            CSR_TRAILER_PATTERN:  tpat_ff <= csr_pwdata;
            default: ;  // unmapped addresses ignore writes
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_SAMPLES_PER_BIT:  csr_prdata = CSR_DATA_W'(spb_ff);
         CSR_ONE_THRESHOLD:    csr_prdata = CSR_DATA_W'(thr_ff);
         CSR_PREAMBLE_PATTERN: csr_prdata = pre_ff;
         CSR_PAYLOAD_BITS:     csr_prdata = CSR_DATA_W'(pay_ff);
         CSR_TRAILER_BITS:     csr_prdata = CSR_DATA_W'(trl_ff);
         CSR_TRAILER_PATTERN:  csr_prdata = tpat_ff;
         default:              csr_prdata = '0;
      endcase
   end

   // ---------------- deframer state ----------------
   logic [7:0]               sc_ff, sc_in;     // samples in current period
   logic [7:0]               hc_ff, hc_in;     // high samples, saturating
   logic [HISTORY_WIDTH-1:0] hist_ff, hist_in;
   logic [5:0]               bip_ff, bip_in;   // bits in phase, saturates at 63
   phase_type                phase_ff, phase_in;
   logic [31:0]              hold_ff, hold_in;
   logic                     marker_ff, marker_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_bit_ff;
   event_type                rsp_event_ff, event_in;
   logic [31:0]              rsp_payload_ff;
   logic                     rsp_marker_ff;

   logic [7:0]               sc_plus, hc_plus;
   logic [5:0]               bip_plus;
   logic                     period_end, bit_dec, take, step;
   logic [HISTORY_WIDTH-1:0] hist_shift;
   logic [CW-1:0]            hist_ext;
   logic                     hit_pre, hit_pay, hit_trl, trl_good, clear_hist;

   // the closing sample is known from the counter alone, so only it waits
   assign req_if.ready = !period_end || !rsp_valid_ff || rsp_if.ready;
   assign take         = req_if.valid && req_if.ready;
   assign step         = take && period_end;

   assign sc_plus    = sc_ff + 8'd1;
   assign period_end = (sc_plus == spb_ff);
   assign hc_plus    = (req_if.level && (hc_ff != HIGH_COUNT_MAX)) ? hc_ff + 8'd1 : hc_ff;
   assign bit_dec    = (hc_plus >= thr_ff);
   assign bip_plus   = (bip_ff != BIT_COUNT_MAX) ? bip_ff + 6'd1 : bip_ff;
   assign hist_shift = {hist_ff[HISTORY_WIDTH-2:0], bit_dec};
   assign hist_ext   = CW'(hist_shift);

   assign hit_pre  = (phase_ff == PH_HUNT) && (hist_ext == CW'(pre_ff));
   assign hit_pay  = (phase_ff == PH_PAYLOAD) && (bip_plus >= pay_ff);
   assign hit_trl  = (phase_ff == PH_TRAILER) && (bip_plus >= trl_ff);
   assign trl_good = (hist_ext == CW'(tpat_ff));
   assign clear_hist = hit_pre || hit_pay;

   // phase next state
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_HUNT:    if (hit_pre) phase_in = PH_PAYLOAD;
         PH_PAYLOAD: if (hit_pay) phase_in = PH_TRAILER;
         PH_TRAILER: if (hit_trl) phase_in = PH_HUNT;
         default:    phase_in = phase_ff;
      endcase
   end

   // event output for the bit that closes now
   always_comb begin
      event_in = EV_NONE;
      unique case (phase_ff)
         PH_HUNT:    if (hit_pre) event_in = EV_PREAMBLE;
         PH_PAYLOAD: if (hit_pay) event_in = EV_PAYLOAD;
         PH_TRAILER: if (hit_trl) event_in = trl_good ? EV_TRAILER_GOOD : EV_TRAILER_BAD;
         default:    event_in = EV_NONE;
      endcase
   end

   always_comb begin
      sc_in     = period_end ? 8'd0 : sc_plus;
      hc_in     = period_end ? 8'd0 : hc_plus;
      hist_in   = clear_hist ? '0 : hist_shift;
      bip_in    = clear_hist ? 6'd0 : bip_plus;
      hold_in   = hit_pay ? hist_ext[31:0] : hold_ff;
      marker_in = marker_ff || hit_pre;
      if (step)
         rsp_valid_in = 1'b1;
      else if (rsp_if.ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff        <= '0;
         hc_ff        <= '0;
         hist_ff      <= '0;
         bip_ff       <= '0;
         phase_ff     <= PH_HUNT;
         hold_ff      <= '0;
         marker_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            sc_ff <= sc_in;
            hc_ff <= hc_in;
         end
         if (step) begin
            hist_ff   <= hist_in;
            bip_ff    <= bip_in;
            phase_ff  <= phase_in;
            hold_ff   <= hold_in;
            marker_ff <= marker_in;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_bit_ff     <= bit_dec;
         rsp_event_ff   <= event_in;
         rsp_payload_ff <= hold_in;
         rsp_marker_ff  <= marker_in;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.bit_value = rsp_bit_ff;
   assign rsp_if.event_res = rsp_event_ff;
   assign rsp_if.payload   = rsp_payload_ff;
   assign rsp_if.marker    = rsp_marker_ff;

endmodule
`default_nettype wire

>>> src/obd_checker.sv
`default_nettype none
module obd_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire obd_pkg::event_type   rsp_event_res,
   input wire logic [31:0]          rsp_payload,
   input wire logic                 rsp_marker
);
   import obd_pkg::*;

   logic seen_marker_ff;

   always_ff @(posedge clock) begin
      if (reset)
         seen_marker_ff <= 1'b0;
      else if (rsp_valid && rsp_ready && rsp_marker)
         seen_marker_ff <= 1'b1;
   end

   // a stalled result word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload) && $stable(rsp_marker))
      else $error("result word dropped or changed under stall");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a preamble event always shows the marker raised
   a_pre_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_PREAMBLE) |-> rsp_marker)
      else $error("preamble reported without marker");

   // marker is sticky once delivered
   a_marker_sticky: assert property (@(posedge clock) disable iff (reset)
      seen_marker_ff && rsp_valid |-> rsp_marker)
      else $error("marker dropped after being set");

endmodule

bind oversampled_bit_deframer_top obd_checker u_obd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_event_res (rsp_if.event_res),
   .rsp_payload   (rsp_if.payload),
   .rsp_marker    (rsp_if.marker)
);
`default_nettype wire

>>> bench/tb_oversampled_bit_deframer_top.sv
`timescale 1ns / 1ps
module tb_oversampled_bit_deframer_top;
   import obd_pkg::*;

   // One expected result word: what the block reports when a bit period closes.
   typedef struct {
      logic        bit_value;
      event_type   ev;
      logic [31:0] payload;
      logic        marker;
   } bit_word_type;

   // Mirrors the slicer and deframer: register copies, running state, and the
   // words still owed by the block in the order they must come out.
   class frame_checker_type;
      logic [7:0]  spb, thr;
      logic [31:0] pre_pat, trl_pat;
      logic [5:0]  pay_len, trl_len;

      logic [7:0]  smp_cnt, hi_cnt;
      logic [31:0] history;
      logic [5:0]  bit_cnt;
      phase_type   ph;
      logic [31:0] pay_hold;
      logic        mark;

      bit_word_type expected_words[$];
      int           errors, words_seen, n_pre, n_pay, n_good, n_bad;

      function void reset_all();
         spb      = SAMPLES_PER_BIT_RESET;
         thr      = ONE_THRESHOLD_RESET;
         pre_pat  = PREAMBLE_PATTERN_RESET;
         pay_len  = PAYLOAD_BITS_RESET;
         trl_len  = TRAILER_BITS_RESET;
         trl_pat  = TRAILER_PATTERN_RESET;
         smp_cnt  = '0;
         hi_cnt   = '0;
         history  = '0;
         bit_cnt  = '0;
         ph       = PH_HUNT;
         pay_hold = '0;
         mark     = 1'b0;
         expected_words.delete();
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] val);
         case (idx)
            CSR_SAMPLES_PER_BIT:  spb     = val[7:0];
            CSR_ONE_THRESHOLD:    thr     = val[7:0];
            CSR_PREAMBLE_PATTERN: pre_pat = val;
            CSR_PAYLOAD_BITS:     pay_len = val[5:0];
            CSR_TRAILER_BITS:     trl_len = val[5:0];
            CSR_TRAILER_PATTERN:  trl_pat = val;
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(csr_index_type idx);
         case (idx)
            CSR_SAMPLES_PER_BIT:  return {24'd0, spb};
            CSR_ONE_THRESHOLD:    return {24'd0, thr};
            CSR_PREAMBLE_PATTERN: return pre_pat;
            CSR_PAYLOAD_BITS:     return {26'd0, pay_len};
            CSR_TRAILER_BITS:     return {26'd0, trl_len};
            CSR_TRAILER_PATTERN:  return trl_pat;
            default:              return '0;
         endcase
      endfunction

      // Called for every accepted sample word.
      function void take_sample(logic lv);
         bit_word_type w;
         logic         b;
         event_type    ev;
         if (lv && hi_cnt != HIGH_COUNT_MAX) hi_cnt++;
         smp_cnt = smp_cnt + 8'd1;      // wraps, so zero means 256 samples
         if (smp_cnt != spb) return;

         b       = (hi_cnt >= thr);
         smp_cnt = '0;
         hi_cnt  = '0;
         if (bit_cnt != BIT_COUNT_MAX) bit_cnt++;
         history = {history[30:0], b};

         ev = EV_NONE;
         if (ph == PH_HUNT && history == pre_pat) begin
            mark    = 1'b1;
            history = '0;
            bit_cnt = '0;
            ph      = PH_PAYLOAD;
            ev      = EV_PREAMBLE;
         end else if (ph == PH_PAYLOAD && bit_cnt >= pay_len) begin
            pay_hold = history;
            history  = '0;
            bit_cnt  = '0;
            ph       = PH_TRAILER;
            ev       = EV_PAYLOAD;
         end else if (ph == PH_TRAILER && bit_cnt >= trl_len) begin
            // history and bit count stay as they are
            ev = (history == trl_pat) ? EV_TRAILER_GOOD : EV_TRAILER_BAD;
            ph = PH_HUNT;
         end

         w.bit_value = b;
         w.ev        = ev;
         w.payload   = pay_hold;
         w.marker    = mark;
         expected_words.push_back(w);
      endfunction

      function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
         if (exp !== act) begin
            errors++;
            if (errors <= 30)
               $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
         end
      endfunction

      function void check_word(logic b, event_type ev, logic [31:0] p, logic m);
         bit_word_type w;
         if (expected_words.size() == 0) begin
            errors++;
            if (errors <= 30)
               $display("%0t: unexpected word, expected none, actual bit %0b ev %0d pay %0h mk %0b",
                        $time, b, ev, p, m);
            return;
         end
         w = expected_words.pop_front();
         words_seen++;
         case (w.ev)
            EV_PREAMBLE:     n_pre++;
            EV_PAYLOAD:      n_pay++;
            EV_TRAILER_GOOD: n_good++;
            EV_TRAILER_BAD:  n_bad++;
            default: ;
         endcase
         compare_field("bit_value", w.bit_value, b);
         compare_field("event_res", w.ev, ev);
         compare_field("payload", w.payload, p);
         compare_field("marker", w.marker, m);
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   obd_req_if req_bus();
   obd_rsp_if rsp_bus();

   logic                  csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   frame_checker_type sb;
   int                samples_sent;
   int                settings_run;
   bit                quiet;   // when set, neither side idles

   oversampled_bit_deframer_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------------
   // Sample driver. Entered and left just after a falling edge; valid is
   // assigned at most once per falling edge.
   // ---------------------------------------------------------------------
   task automatic push_level(input logic lv);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.level <= lv;
      // a closing sample waits while the result register is full and not draining
      do @(posedge clock); while (!req_bus.ready);
      sb.take_sample(lv);
      samples_sent++;
      @(negedge clock);
   endtask

   // One bit period of len samples with exactly highs of them high, spread
   // uniformly over the period.
   task automatic push_period(input int highs, input int len);
      int   left, h;
      logic lv;
      left = len;
      h    = highs;
      while (left > 0) begin
         lv = (h > 0) && ($urandom_range(1, left) <= h);
         if (lv) h--;
         left--;
         push_level(lv);
      end
   endtask

   // Encode one bit under the current settings, with a random number of
   // high samples on the right side of the threshold where that is possible.
   task automatic send_bit(input logic b);
      int len, t, highs;
      len = (sb.spb == 0) ? 256 : sb.spb;
      t   = sb.thr;
      if (b && t <= len)
         highs = $urandom_range(t, len);
      else if (!b && t > 0)
         highs = $urandom_range(0, (t - 1 < len) ? t - 1 : len);
      else
         highs = $urandom_range(0, len);
      push_period(highs, len);
   endtask

   task automatic send_random_bits(input int n);
      repeat (n) send_bit($urandom_range(0, 1));
   endtask

   task automatic send_pattern(input logic [31:0] pat);
      for (int i = 31; i >= 0; i--) send_bit(pat[i]);
   endtask

   // A frame: mostly well-formed (preamble, random payload, trailer that is
   // good or carries one flipped bit), some cut short, some pure noise.
   task automatic run_frame();
      int   r, n, flip;
      logic b;
      r = $urandom_range(0, 9);
      send_random_bits($urandom_range(0, 3));
      if (r < 7) begin
         send_pattern(sb.pre_pat);
         n = (sb.pay_len == 0) ? 1 : sb.pay_len;
         send_random_bits(n);
         n    = (sb.trl_len == 0) ? 1 : sb.trl_len;
         flip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ((n < 32) ? n : 32) - 1) : -1;
         for (int i = n - 1; i >= 0; i--) begin
            b = (i < 32) ? sb.trl_pat[i] : logic'($urandom_range(0, 1));
            if (i == flip) b = ~b;
            send_bit(b);
         end
      end else if (r < 9) begin
         send_pattern(sb.pre_pat);
         send_random_bits($urandom_range(1, 8));
      end else begin
         send_random_bits($urandom_range(4, 12));
      end
   endtask

   // ---------------------------------------------------------------------
   // APB port: setup, access, then idle with psel low so no signal gets two
   // assignments at one falling edge.
   // ---------------------------------------------------------------------
   task automatic apb_transfer(input logic wr, input csr_index_type idx,
                               input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Write a register, mirror it, and read it back.
   task automatic program_reg(input csr_index_type idx, input logic [31:0] val);
      logic [31:0] rd, want;
      apb_transfer(1'b1, idx, val, rd);
      sb.write_reg(idx, val);
      apb_transfer(1'b0, idx, 32'd0, rd);
      want = sb.reg_value(idx);
      if (rd !== want) begin
         sb.errors++;
         $display("%0t: readback of register %s, expected %0h, actual %0h",
                  $time, idx.name(), want, rd);
      end
   endtask

   task automatic apply_settings(input logic [31:0] spb, input logic [31:0] thr,
                                 input logic [31:0] pre, input logic [31:0] pay,
                                 input logic [31:0] trl, input logic [31:0] tpat);
      program_reg(CSR_SAMPLES_PER_BIT, spb);
      program_reg(CSR_ONE_THRESHOLD, thr);
      program_reg(CSR_PREAMBLE_PATTERN, pre);
      program_reg(CSR_PAYLOAD_BITS, pay);
      program_reg(CSR_TRAILER_BITS, trl);
      program_reg(CSR_TRAILER_PATTERN, tpat);
      settings_run++;
   endtask

   // Drop valid and wait for the block to drain. Samples that close no period
   // leave nothing owed; the wait after the queue empties covers the result register.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [31:0] low_mask(input int n);
      return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
   endfunction

   // One configuration followed by one frame; the zero register gets a single
   // long period instead.
   task automatic run_setting(input int idx);
      int          frames, spb, trl;
      logic [31:0] tpat;
      frames = 1;
      quiet  = 1'b0;
      case (idx)
         0: begin   // one sample per bit, no idling at all
            quiet = 1'b1;
            apply_settings(1, 1, $urandom, 8, 8, $urandom_range(0, 255));
         end
         1: begin   // lengths of 32, all-ones preamble
            apply_settings(1, 1, 32'hFFFF_FFFF, 32, 32, $urandom);
         end
         2: begin   // threshold zero: every bit decides one
            apply_settings(3, 0, 32'hFFFF_FFFF, 1, 1, 1);
         end
         3: begin   // threshold above the period: every bit is zero; max lengths
            apply_settings(1, 2, 0, 63, 63, 0);
         end
         4, 5: begin
            spb  = $urandom_range(1, 2);
            trl  = $urandom_range(1, 12);
            tpat = $urandom & low_mask(trl);
            apply_settings(spb, $urandom_range(1, spb), $urandom, $urandom_range(1, 12),
                           trl, tpat);
         end
         6: begin   // zero register: 256-sample period, high count saturates
            quiet = 1'b1;
            apply_settings(0, 255, $urandom, $urandom_range(1, 63), $urandom_range(1, 63),
                           $urandom);
            push_period(256, 256);
            frames = 0;
         end
         default: begin   // zero lengths possible, random patterns
            spb  = $urandom_range(1, 2);
            trl  = $urandom_range(0, 32);
            tpat = ($urandom_range(0, 1) != 0) ? ($urandom & low_mask(trl)) : $urandom;
            apply_settings(spb, $urandom_range(0, spb), $urandom, $urandom_range(0, 32),
                           trl, tpat);
         end
      endcase
      repeat (frames) run_frame();
      settle();
   endtask

   // ---------------------------------------------------------------------
   // Result side: ready idles at random; every accepted word is checked.
   // ---------------------------------------------------------------------
   initial begin
      int n;
      rsp_bus.ready <= 1'b0;
      while (reset) @(negedge clock);
      forever begin
         n = idle_len();
         if (n > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_word(rsp_bus.bit_value, rsp_bus.event_res, rsp_bus.payload, rsp_bus.marker);
   end

   // Main sequence.
   initial begin
      req_bus.valid <= 1'b0;
      req_bus.level <= 1'b0;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      samples_sent  = 0;
      settings_run  = 0;
      quiet         = 1'b0;
      sb = new();
      sb.reset_all();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: a period with exactly the threshold of highs (one),
      // then one high short of it (zero).
      push_period(7, 10);
      push_period(6, 10);
      settle();

      // Zero preamble matches the cleared history; zero payload and trailer
      // lengths close each phase on its first bit; trailer zero is good.
      apply_settings(1, 1, 0, 0, 0, 0);
      push_level(1'b0);
      push_level(1'b1);
      push_level(1'b0);
      push_level(1'b1);
      push_level(1'b0);
      settle();

      for (int s = 0; s < 9; s++) run_setting(s);

      repeat (10) @(negedge clock);
      $display("Checked %0d result words from %0d samples over %0d register settings.",
               sb.words_seen, samples_sent, settings_run);
      $display("Events: %0d preambles, %0d payloads, %0d good and %0d bad trailers.",
               sb.n_pre, sb.n_pay, sb.n_good, sb.n_bad);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         if (sb.pending() != 0)
            $display("%0t: %0d expected words never arrived", $time, sb.pending());
         $display("Mismatches found");
      end
      $finish;
   end

   // Hang guard, far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

>>> filelist.f
src/obd_pkg.sv
src/obd_if.sv
src/oversampled_bit_deframer_top.sv
src/obd_checker.sv
bench/tb_oversampled_bit_deframer_top.sv
